// ----- src/spq_pkg.sv -----
package spq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_PEEK   = 2'd2,
    OP_CLEAR  = 2'd3
  } spq_op_t;

  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } spq_status_t;

  typedef struct packed {
    logic capture;
    logic do_insert;
    logic do_delete;
    logic do_clear;
    logic take_head;
  } spq_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic full;
  } spq_stat_t;

endpackage

// ----- src/spq_if.sv -----
interface spq_in_if #(
  parameter int DATA_BITS = 32,
  parameter int PRIO_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic signed [DATA_BITS-1:0] item_data;
  logic signed [PRIO_BITS-1:0] item_priority;

  modport source (output valid, operation, item_data, item_priority, input ready);
  modport sink   (input valid, operation, item_data, item_priority, output ready);
endinterface

interface spq_out_if #(
  parameter int DATA_BITS = 32,
  parameter int PRIO_BITS = 16,
  parameter int CNT_BITS  = 5
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic signed [DATA_BITS-1:0] out_data;
  logic signed [PRIO_BITS-1:0] out_priority;
  logic                        now_empty;
  logic [CNT_BITS-1:0]         entry_total;

  modport source (output valid, status, out_data, out_priority, now_empty, entry_total,
                  input ready);
  modport sink   (input valid, status, out_data, out_priority, now_empty, entry_total,
                  output ready);
endinterface

// ----- src/sorted_priority_queue_top.sv -----
// Sorted priority queue, ascending priority, head served first.
// A result is registered and shown in the cycle after its item is accepted.
// Throughput: one item per cycle unless stalled; every slot compares and shifts in parallel.
// The output register frees when its beat is taken, so input is held off only under stall.
// Reset (synchronous, rst_n low) empties the queue; slot contents stay unknown.
module sorted_priority_queue_top #(
  parameter int CAPACITY  = 16,
  parameter int DATA_BITS = 32,
  parameter int PRIO_BITS = 16,
  parameter int CNT_BITS  = 5
) (
  input logic      clk,
  input logic      rst_n,
  spq_in_if.sink   in_bus,
  spq_out_if.source out_bus
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_bus.valid),
    .in_ready     (in_bus.ready),
    .in_operation (in_bus.operation),
    .out_valid    (out_bus.valid),
    .out_ready    (out_bus.ready),
    .out_status   (out_bus.status),
    .cmd          (cmd),
    .stat         (stat)
  );

  spq_datapath #(
    .CAPACITY  (CAPACITY),
    .DATA_BITS (DATA_BITS),
    .PRIO_BITS (PRIO_BITS),
    .CNT_BITS  (CNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .item_data     (in_bus.item_data),
    .item_priority (in_bus.item_priority),
    .res_data      (out_bus.out_data),
    .res_priority  (out_bus.out_priority),
    .res_empty     (out_bus.now_empty),
    .res_count     (out_bus.entry_total)
  );

endmodule

// ----- src/spq_datapath.sv -----
module spq_datapath #(
  parameter int CAPACITY  = 16,
  parameter int DATA_BITS = 32,
  parameter int PRIO_BITS = 16,
  parameter int CNT_BITS  = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  spq_pkg::spq_cmd_t           cmd,
  output spq_pkg::spq_stat_t          stat,
  input  logic signed [DATA_BITS-1:0] item_data,
  input  logic signed [PRIO_BITS-1:0] item_priority,
  output logic signed [DATA_BITS-1:0] res_data,
  output logic signed [PRIO_BITS-1:0] res_priority,
  output logic                        res_empty,
  output logic [CNT_BITS-1:0]         res_count
);
  import spq_pkg::*;

  logic signed [DATA_BITS-1:0] slot_data_r     [CAPACITY];
  logic signed [PRIO_BITS-1:0] slot_priority_r [CAPACITY];
  logic [CAPACITY-1:0]         keep;
  logic [CNT_BITS-1:0]         count_r;
  logic [CNT_BITS-1:0]         count_nxt;
  logic signed [DATA_BITS-1:0] res_data_r;
  logic signed [PRIO_BITS-1:0] res_priority_r;
  logic                        res_empty_r;
  logic [CNT_BITS-1:0]         res_count_r;

  // A slot keeps its entry on insert when it sits ahead of the new one.
  // The head wins ties; every other slot yields to an equal priority.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        keep[i] = (count_r != '0) && (slot_priority_r[i] <= item_priority);
      end else begin
        keep[i] = (CNT_BITS'(i) < count_r) && (slot_priority_r[i] < item_priority);
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_slot
      logic signed [DATA_BITS-1:0] up_data;
      logic signed [PRIO_BITS-1:0] up_priority;
      logic                        take_new;

      if (g == 0) begin : g_head
        assign take_new = 1'b1;
      end else begin : g_body
        assign take_new = keep[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
        assign up_data     = slot_data_r[g];
        assign up_priority = slot_priority_r[g];
      end else begin : g_mid
        assign up_data     = slot_data_r[g+1];
        assign up_priority = slot_priority_r[g+1];
      end

      always_ff @(posedge clk) begin
        if (cmd.do_insert && !keep[g]) begin
          if (take_new) begin
            slot_data_r[g]     <= item_data;
            slot_priority_r[g] <= item_priority;
          end else begin
            slot_data_r[g]     <= slot_data_r[(g == 0) ? 0 : g - 1];
            slot_priority_r[g] <= slot_priority_r[(g == 0) ? 0 : g - 1];
          end
        end else if (cmd.do_delete) begin
          slot_data_r[g]     <= up_data;
          slot_priority_r[g] <= up_priority;
        end
      end
    end
  endgenerate

  always_comb begin
    priority if (cmd.do_clear) begin
      count_nxt = '0;
    end else if (cmd.do_insert) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (cmd.do_delete) begin
      count_nxt = count_r - CNT_BITS'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_data_r     <= cmd.take_head ? slot_data_r[0] : '0;
      res_priority_r <= cmd.take_head ? slot_priority_r[0] : '0;
      res_empty_r    <= (count_nxt == '0);
      res_count_r    <= count_nxt;
    end
  end

  assign stat.cnt_zero = (count_r == '0);
  assign stat.full     = (count_r == CNT_BITS'(CAPACITY));
  assign res_data      = res_data_r;
  assign res_priority  = res_priority_r;
  assign res_empty     = res_empty_r;
  assign res_count     = res_count_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(CAPACITY))
    else $error("entry count above capacity");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_insert |-> !stat.full)
    else $error("insert issued into a full queue");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_clear |=> count_r == '0)
    else $error("count not zero after clear");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_insert |=> count_r == $past(count_r) + CNT_BITS'(1))
    else $error("count did not advance on insert");
`endif

endmodule

// ----- src/spq_ctrl.sv -----
module spq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_operation,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output spq_pkg::spq_cmd_t    cmd,
  input  spq_pkg::spq_stat_t   stat
);
  import spq_pkg::*;

  typedef enum logic {
    IDLE,
    HOLD
  } state_t;

  state_t      state_r;
  spq_status_t status_r;
  spq_status_t status_nxt;
  spq_op_t     op;
  logic        fire;

  assign op       = spq_op_t'(in_operation);
  assign in_ready = (state_r == IDLE) || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    status_nxt = STS_DONE;
    cmd.capture = fire;
    if (fire) begin
      unique case (op)
        OP_INSERT: begin
          cmd.do_insert = !stat.full;
          status_nxt    = stat.full ? STS_FULL : STS_DONE;
        end
        OP_DELETE: begin
          cmd.do_delete = !stat.cnt_zero;
          cmd.take_head = !stat.cnt_zero;
          status_nxt    = stat.cnt_zero ? STS_EMPTY : STS_DONE;
        end
        OP_PEEK: begin
          cmd.take_head = !stat.cnt_zero;
          status_nxt    = stat.cnt_zero ? STS_EMPTY : STS_DONE;
        end
        OP_CLEAR: begin
          cmd.do_clear = 1'b1;
        end
      endcase
    end
  end

  // Hold the result beat until taken; a new beat may replace it the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else if (fire) begin
      state_r  <= HOLD;
      status_r <= status_nxt;
    end else if (out_ready) begin
      state_r <= IDLE;
    end
  end

  assign out_valid  = (state_r == HOLD);
  assign out_status = status_r;

`ifndef SYNTH
  a_valid_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(fire))
    else $error("result shown without an accepted beat");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.do_insert, cmd.do_delete, cmd.do_clear}) <= 1)
    else $error("more than one queue update at once");
`endif

endmodule
